@@ src/rrc_pkg.sv @@
// shared types, codes and defaults for the request replay cache
package rrc_pkg;

  localparam int DEF_ENTRY_DEPTH = 16;
  localparam int DEF_PEER_DEPTH  = 8;
  localparam logic [63:0] AGE_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    CMD_LOOKUP  = 3'd0,
    CMD_BEGIN   = 3'd1,
    CMD_PREPARE = 3'd2,
    CMD_MARK    = 3'd3,
    CMD_REMOVE  = 3'd4
  } cmd_e_t;

  typedef enum logic [1:0] {
    ST_EMPTY     = 2'd0,
    ST_PENDING   = 2'd1,
    ST_PREPARED  = 2'd2,
    ST_RESPONDED = 2'd3
  } ent_st_t;

  typedef enum logic [2:0] {
    LS_MISS      = 3'd0,
    LS_COLLISION = 3'd1,
    LS_PENDING   = 3'd2,
    LS_PREPARED  = 3'd3,
    LS_RESPONDED = 3'd4,
    LS_STALE     = 3'd5
  } lk_st_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_PSCAN,
    FSM_ESCAN,
    FSM_COMMIT
  } fsm_t;

  typedef struct packed {
    logic load;
    logic pscan;
    logic escan;
    logic commit;
  } ctl_t;

  typedef struct packed {
    logic scan_end;
  } sts_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [63:0] id;
    logic [63:0] digest;
    logic [63:0] age;
  } ent_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [15:0] port;
    logic [63:0] hid;
    logic [63:0] age;
  } peer_t;

endpackage

@@ src/rrc_ctrl.sv @@
// command sequencer: peer scan, entry scan, commit
module rrc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [2:0]    in_command,
  input  rrc_pkg::sts_t sts,
  output rrc_pkg::ctl_t ctl,
  output logic          busy
);

  rrc_pkg::fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrc_pkg::FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rrc_pkg::FSM_IDLE: begin
        if (start) begin
          if (in_command == rrc_pkg::CMD_LOOKUP || in_command == rrc_pkg::CMD_BEGIN) begin
            state_nxt = rrc_pkg::FSM_PSCAN;
          end else begin
            state_nxt = rrc_pkg::FSM_COMMIT;
          end
        end
      end
      rrc_pkg::FSM_PSCAN: begin
        if (sts.scan_end) state_nxt = rrc_pkg::FSM_ESCAN;
      end
      rrc_pkg::FSM_ESCAN: begin
        if (sts.scan_end) state_nxt = rrc_pkg::FSM_COMMIT;
      end
      rrc_pkg::FSM_COMMIT: begin
        state_nxt = rrc_pkg::FSM_IDLE;
      end
      default: state_nxt = rrc_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    busy = 1'b1;
    unique case (state_r)
      rrc_pkg::FSM_IDLE: begin
        busy = 1'b0;
        ctl.load = start;
      end
      rrc_pkg::FSM_PSCAN:  ctl.pscan = 1'b1;
      rrc_pkg::FSM_ESCAN:  ctl.escan = 1'b1;
      rrc_pkg::FSM_COMMIT: ctl.commit = 1'b1;
      default: busy = 1'b1;
    endcase
  end

endmodule

@@ src/rrc_dp.sv @@
// tables, scan compare units, commit logic and result registers
module rrc_dp #(
  parameter int ENTRY_DEPTH = rrc_pkg::DEF_ENTRY_DEPTH,
  parameter int PEER_DEPTH  = rrc_pkg::DEF_PEER_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rrc_pkg::ctl_t ctl,
  output rrc_pkg::sts_t sts,
  input  logic [2:0]    in_command,
  input  logic [31:0]   in_peer_address,
  input  logic [15:0]   in_peer_port,
  input  logic [63:0]   in_request_id,
  input  logic [63:0]   in_request_digest,
  input  logic [3:0]    in_target_slot,
  input  logic [63:0]   in_response_in,
  output logic          out_valid,
  output logic [2:0]    out_lookup_status,
  output logic          out_accepted,
  output logic          out_slot_valid,
  output logic [3:0]    out_slot_index,
  output logic          out_response_valid,
  output logic [63:0]   out_response_value,
  output logic [4:0]    out_occupied_count,
  output logic [31:0]   out_collision_total,
  output logic [31:0]   out_coalesced_total,
  output logic [31:0]   out_replayed_total,
  output logic [31:0]   out_stale_total,
  output logic [31:0]   out_eviction_total
);

  localparam int AW   = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
  localparam int PW   = (PEER_DEPTH > 1) ? $clog2(PEER_DEPTH) : 1;
  localparam int MAXD = (ENTRY_DEPTH > PEER_DEPTH) ? ENTRY_DEPTH : PEER_DEPTH;
  localparam int CW   = $clog2(MAXD + 1);
  localparam int TW   = ((AW > 4) ? AW : 4) + 1;
  localparam int OW   = $clog2(ENTRY_DEPTH + 1);

  // latched request
  logic [2:0]  cmd_r;
  logic [31:0] addr_r;
  logic [15:0] port_r;
  logic [63:0] id_r;
  logic [63:0] dig_r;
  logic [3:0]  ts_r;
  logic [63:0] resp_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_command;
      addr_r <= in_peer_address;
      port_r <= in_peer_port;
      id_r   <= in_request_id;
      dig_r  <= in_request_digest;
      ts_r   <= in_target_slot;
      resp_r <= in_response_in;
    end
  end

  // scan counter and compare stage
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cmp_idx_r;
  logic          cmp_vld_r;
  logic          cmp_peer_r;
  logic          scanning;

  assign scanning = ctl.pscan | ctl.escan;
  assign sts.scan_end = (ctl.pscan && cnt_r == CW'(PEER_DEPTH)) ||
                        (ctl.escan && cnt_r == CW'(ENTRY_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      if (ctl.load || sts.scan_end) begin
        cnt_r <= '0;
      end else if (scanning) begin
        cnt_r <= cnt_r + 1'b1;
      end
      cmp_vld_r <= scanning && !sts.scan_end;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r  <= cnt_r;
    cmp_peer_r <= ctl.pscan;
  end

  // tables
  rrc_pkg::ent_st_t st_r [ENTRY_DEPTH];
  logic             present_r [PEER_DEPTH];
  rrc_pkg::ent_t    ent_mem [ENTRY_DEPTH];
  logic [63:0]      rsp_mem [ENTRY_DEPTH];
  rrc_pkg::peer_t   peer_mem [PEER_DEPTH];
  rrc_pkg::ent_t    ent_rd_r;
  logic [63:0]      rsp_rd_r;
  rrc_pkg::peer_t   peer_rd_r;

  logic [AW-1:0] ent_ra, ci_e;
  logic [PW-1:0] peer_ra, ci_p;
  assign ent_ra  = cnt_r[AW-1:0];
  assign peer_ra = cnt_r[PW-1:0];
  assign ci_e    = cmp_idx_r[AW-1:0];
  assign ci_p    = cmp_idx_r[PW-1:0];

  // scan results
  logic          pf_r;
  logic [PW-1:0] pfi_r;
  logic [63:0]   phid_r;
  logic          vabs_r;
  logic [PW-1:0] vidx_r;
  logic [63:0]   vbest_r;
  logic          hit_r;
  logic [AW-1:0] hidx_r;
  rrc_pkg::ent_st_t hst_r;
  logic          hdeq_r;
  logic [63:0]   hresp_r;
  logic          sabs_r;
  logic          selv_r;
  logic [AW-1:0] selidx_r;
  logic [63:0]   sbest_r;

  rrc_pkg::ent_st_t cst;
  assign cst = st_r[ci_e];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pf_r    <= 1'b0;
      vabs_r  <= 1'b0;
      vidx_r  <= '0;
      vbest_r <= rrc_pkg::AGE_MAX;
      hit_r   <= 1'b0;
      sabs_r  <= 1'b0;
      selv_r  <= 1'b0;
      sbest_r <= rrc_pkg::AGE_MAX;
    end else if (cmp_vld_r && cmp_peer_r) begin
      if (!pf_r && present_r[ci_p] && peer_rd_r.addr == addr_r &&
          peer_rd_r.port == port_r) begin
        pf_r   <= 1'b1;
        pfi_r  <= ci_p;
        phid_r <= peer_rd_r.hid;
      end
      if (!vabs_r) begin
        if (!present_r[ci_p]) begin
          vabs_r <= 1'b1;
          vidx_r <= ci_p;
        end else if (peer_rd_r.age < vbest_r) begin
          vbest_r <= peer_rd_r.age;
          vidx_r  <= ci_p;
        end
      end
    end else if (cmp_vld_r) begin
      if (!hit_r && cst != rrc_pkg::ST_EMPTY && ent_rd_r.addr == addr_r &&
          ent_rd_r.port == port_r && ent_rd_r.id == id_r) begin
        hit_r   <= 1'b1;
        hidx_r  <= ci_e;
        hst_r   <= cst;
        hdeq_r  <= (ent_rd_r.digest == dig_r);
        hresp_r <= rsp_rd_r;
      end
      if (!sabs_r) begin
        if (cst == rrc_pkg::ST_EMPTY) begin
          sabs_r   <= 1'b1;
          selv_r   <= 1'b1;
          selidx_r <= ci_e;
        end else if (cst == rrc_pkg::ST_RESPONDED && ent_rd_r.age < sbest_r) begin
          sbest_r  <= ent_rd_r.age;
          selv_r   <= 1'b1;
          selidx_r <= ci_e;
        end
      end
    end
  end

  // commit decisions
  logic [63:0]   id_diff;
  logic          stale;
  logic          is_lookup, is_begin, is_prep, is_mark, is_remove;
  logic [TW-1:0] ts_ext;
  logic          ts_ok;
  logic [AW-1:0] tsi;
  rrc_pkg::ent_st_t tst;
  logic          beg_ok, prep_ok, mark_ok, rem_ok;
  logic [PW-1:0] pwa;
  rrc_pkg::ent_t  ent_wd;
  rrc_pkg::peer_t peer_wd;

  logic [63:0] age_r;
  logic [31:0] coll_r, coal_r, repl_r, stale_r, evict_r;
  logic [OW-1:0] occ_r;

  assign id_diff   = id_r - phid_r;
  assign stale     = pf_r && !(id_diff != 64'd0 && !id_diff[63]);
  assign is_lookup = (cmd_r == rrc_pkg::CMD_LOOKUP);
  assign is_begin  = (cmd_r == rrc_pkg::CMD_BEGIN);
  assign is_prep   = (cmd_r == rrc_pkg::CMD_PREPARE);
  assign is_mark   = (cmd_r == rrc_pkg::CMD_MARK);
  assign is_remove = (cmd_r == rrc_pkg::CMD_REMOVE);
  assign ts_ext    = TW'(ts_r);
  assign ts_ok     = (ts_ext < TW'(ENTRY_DEPTH));
  assign tsi       = ts_ext[AW-1:0];
  assign tst       = st_r[tsi];
  assign beg_ok    = ctl.commit && is_begin && !stale && selv_r;
  assign prep_ok   = ctl.commit && is_prep && ts_ok && tst == rrc_pkg::ST_PENDING;
  assign mark_ok   = ctl.commit && is_mark && ts_ok && tst == rrc_pkg::ST_PREPARED;
  assign rem_ok    = ctl.commit && is_remove && ts_ok && tst != rrc_pkg::ST_EMPTY;
  assign pwa       = pf_r ? pfi_r : vidx_r;
  assign ent_wd    = '{addr: addr_r, port: port_r, id: id_r, digest: dig_r, age: age_r};
  assign peer_wd   = '{addr: addr_r, port: port_r, hid: id_r, age: age_r};

  // memories
  always_ff @(posedge clk) begin
    if (beg_ok) ent_mem[selidx_r] <= ent_wd;
    if (prep_ok) rsp_mem[tsi] <= resp_r;
    ent_rd_r <= ent_mem[ent_ra];
    rsp_rd_r <= rsp_mem[ent_ra];
  end

  always_ff @(posedge clk) begin
    if (beg_ok) peer_mem[pwa] <= peer_wd;
    peer_rd_r <= peer_mem[peer_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRY_DEPTH; i++) st_r[i] <= rrc_pkg::ST_EMPTY;
      for (int j = 0; j < PEER_DEPTH; j++) present_r[j] <= 1'b0;
      age_r   <= 64'd1;
      coll_r  <= '0;
      coal_r  <= '0;
      repl_r  <= '0;
      stale_r <= '0;
      evict_r <= '0;
      occ_r   <= '0;
    end else begin
      if (ctl.commit && is_lookup) begin
        if (hit_r) begin
          if (!hdeq_r) begin
            coll_r <= coll_r + 32'd1;
          end else if (hst_r == rrc_pkg::ST_RESPONDED) begin
            repl_r <= repl_r + 32'd1;
          end else begin
            coal_r <= coal_r + 32'd1;
          end
        end else if (stale) begin
          stale_r <= stale_r + 32'd1;
        end
      end
      if (beg_ok) begin
        present_r[pwa] <= 1'b1;
        st_r[selidx_r] <= rrc_pkg::ST_PENDING;
        if (st_r[selidx_r] == rrc_pkg::ST_EMPTY) begin
          occ_r <= occ_r + 1'b1;
        end else begin
          evict_r <= evict_r + 32'd1;
        end
        age_r <= (age_r == rrc_pkg::AGE_MAX) ? 64'd1 : age_r + 64'd1;
      end
      if (prep_ok) st_r[tsi] <= rrc_pkg::ST_PREPARED;
      if (mark_ok) st_r[tsi] <= rrc_pkg::ST_RESPONDED;
      if (rem_ok) begin
        st_r[tsi] <= rrc_pkg::ST_EMPTY;
        occ_r <= occ_r - 1'b1;
      end
    end
  end

  // result registers
  logic [2:0]  ls_r, ls_nxt;
  logic        acc_r, sv_r, rv_r, ovld_r;
  logic        sv_nxt, rv_nxt;
  logic [3:0]  sidx_r, sidx_nxt;
  logic [63:0] rval_r, rval_nxt;

  always_comb begin
    ls_nxt   = rrc_pkg::LS_MISS;
    sv_nxt   = 1'b0;
    sidx_nxt = 4'd0;
    rv_nxt   = 1'b0;
    rval_nxt = 64'd0;
    if (is_lookup && hit_r) begin
      sv_nxt   = 1'b1;
      sidx_nxt = 4'(hidx_r);
      if (!hdeq_r) begin
        ls_nxt = rrc_pkg::LS_COLLISION;
      end else if (hst_r == rrc_pkg::ST_PENDING) begin
        ls_nxt = rrc_pkg::LS_PENDING;
      end else begin
        rv_nxt   = 1'b1;
        rval_nxt = hresp_r;
        ls_nxt   = (hst_r == rrc_pkg::ST_PREPARED) ? rrc_pkg::LS_PREPARED
                                                    : rrc_pkg::LS_RESPONDED;
      end
    end else if (is_lookup && stale) begin
      ls_nxt = rrc_pkg::LS_STALE;
    end else if (beg_ok) begin
      sv_nxt   = 1'b1;
      sidx_nxt = 4'(selidx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= ctl.commit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      ls_r   <= ls_nxt;
      acc_r  <= beg_ok | prep_ok | mark_ok | rem_ok;
      sv_r   <= sv_nxt;
      sidx_r <= sidx_nxt;
      rv_r   <= rv_nxt;
      rval_r <= rval_nxt;
    end
  end

  assign out_valid           = ovld_r;
  assign out_lookup_status   = ls_r;
  assign out_accepted        = acc_r;
  assign out_slot_valid      = sv_r;
  assign out_slot_index      = sidx_r;
  assign out_response_valid  = rv_r;
  assign out_response_value  = rval_r;
  assign out_occupied_count  = 5'(occ_r);
  assign out_collision_total = coll_r;
  assign out_coalesced_total = coal_r;
  assign out_replayed_total  = repl_r;
  assign out_stale_total     = stale_r;
  assign out_eviction_total  = evict_r;

endmodule

@@ src/request_replay_cache.sv @@
// duplicate-request replay cache: top level
// lookup and begin: the request is latched, then the peer table and then the entry table
//   are scanned one slot per cycle, and the commit state registers the strobe
// prepare, mark responded, remove and unknown commands: no scans, straight to the commit state
// one request in flight; busy drops in the strobe cycle, results cannot be stalled
// synchronous reset empties all entries and peers, zeroes counters, sets the age to one
module request_replay_cache #(
  parameter int ENTRY_DEPTH = rrc_pkg::DEF_ENTRY_DEPTH,
  parameter int PEER_DEPTH  = rrc_pkg::DEF_PEER_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_peer_address,
  input  logic [15:0] in_peer_port,
  input  logic [63:0] in_request_id,
  input  logic [63:0] in_request_digest,
  input  logic [3:0]  in_target_slot,
  input  logic [63:0] in_response_in,
  output logic        out_valid,
  output logic [2:0]  out_lookup_status,
  output logic        out_accepted,
  output logic        out_slot_valid,
  output logic [3:0]  out_slot_index,
  output logic        out_response_valid,
  output logic [63:0] out_response_value,
  output logic [4:0]  out_occupied_count,
  output logic [31:0] out_collision_total,
  output logic [31:0] out_coalesced_total,
  output logic [31:0] out_replayed_total,
  output logic [31:0] out_stale_total,
  output logic [31:0] out_eviction_total
);

  rrc_pkg::ctl_t ctl;
  rrc_pkg::sts_t sts;

  rrc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .ctl        (ctl),
    .busy       (busy)
  );

  rrc_dp #(
    .ENTRY_DEPTH (ENTRY_DEPTH),
    .PEER_DEPTH  (PEER_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .sts                 (sts),
    .in_command          (in_command),
    .in_peer_address     (in_peer_address),
    .in_peer_port        (in_peer_port),
    .in_request_id       (in_request_id),
    .in_request_digest   (in_request_digest),
    .in_target_slot      (in_target_slot),
    .in_response_in      (in_response_in),
    .out_valid           (out_valid),
    .out_lookup_status   (out_lookup_status),
    .out_accepted        (out_accepted),
    .out_slot_valid      (out_slot_valid),
    .out_slot_index      (out_slot_index),
    .out_response_valid  (out_response_valid),
    .out_response_value  (out_response_value),
    .out_occupied_count  (out_occupied_count),
    .out_collision_total (out_collision_total),
    .out_coalesced_total (out_coalesced_total),
    .out_replayed_total  (out_replayed_total),
    .out_stale_total     (out_stale_total),
    .out_eviction_total  (out_eviction_total)
  );

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("strobe while busy");

  a_strobe_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("strobe without a request in flight");

  a_accept_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_lookup_status == rrc_pkg::LS_MISS)
    else $error("status on a non-lookup result");

  a_resp_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_response_valid |-> out_slot_valid)
    else $error("response without a matched slot");

endmodule
